>>> hw/rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared constants, types and the CRC-8 fold for the SLIP frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int BYTE_W = 8;
  localparam int SLOT_W = 4;

  // SLIP framing codes
  localparam logic [BYTE_W-1:0] FEND    = 8'hC0;
  localparam logic [BYTE_W-1:0] FESC    = 8'hDB;
  localparam logic [BYTE_W-1:0] TFEND   = 8'hDC;
  localparam logic [BYTE_W-1:0] TFESC   = 8'hDD;
  localparam logic [BYTE_W-1:0] HDR_PAD = 8'h00;

  // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  // One framed item, as handed from the framer to the emitter
  typedef struct packed {
    logic              hdr;      // send the five-byte header first
    logic              data_en;  // send an escaped payload byte
    logic [BYTE_W-1:0] data;
    logic              crc_en;   // send escaped CRC and the closing byte
    logic [BYTE_W-1:0] crc;
  } job_t;

  // Fold one byte into the running CRC, one bit per step
  function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] v;
    v = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

  // True where a byte needs a SLIP escape pair
  function automatic logic needs_escape(input logic [BYTE_W-1:0] b);
    return (b == FEND) || (b == FESC);
  endfunction

endpackage

>>> hw/rtl/sfe_framer.sv
// ----------------------------------------------------------------------------
// sfe_framer
// Input stage: holds the frame state (open flag, running CRC) and registers
// one job per accepted transaction for the emitter.
// ----------------------------------------------------------------------------
module sfe_framer
  import sfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] payload_byte,
  input  logic              last_byte,
  input  logic              empty_frame,
  input  logic              job_pop,
  output logic              job_valid,
  output job_t              job
);

  logic              frame_open;
  logic [BYTE_W-1:0] running_crc;
  logic              frame_open_next;
  logic [BYTE_W-1:0] running_crc_next;
  job_t              job_next;
  logic [BYTE_W-1:0] crc_base;
  logic [BYTE_W-1:0] crc_new;
  logic              accept;

  // Take a new transaction when the job slot is free or emptying
  assign in_ready = !job_valid || job_pop;
  assign accept   = in_valid && in_ready;

  // Fold the payload byte; a new frame starts from the initial value
  assign crc_base = frame_open ? running_crc : CRC_INIT;
  assign crc_new  = crc8_fold(crc_base, payload_byte);

  // Build the job and the next frame state
  always_comb begin
    job_next         = '0;
    frame_open_next  = frame_open;
    running_crc_next = running_crc;
    if (empty_frame) begin
      job_next.hdr     = 1'b1;
      job_next.data_en = 1'b0;
      job_next.data    = payload_byte;
      job_next.crc_en  = 1'b1;
      job_next.crc     = CRC_INIT;
      frame_open_next  = 1'b0;
      running_crc_next = CRC_INIT;
    end else begin
      job_next.hdr     = !frame_open;
      job_next.data_en = 1'b1;
      job_next.data    = payload_byte;
      job_next.crc_en  = last_byte;
      job_next.crc     = crc_new;
      if (last_byte) begin
        frame_open_next  = 1'b0;
        running_crc_next = CRC_INIT;
      end else begin
        frame_open_next  = 1'b1;
        running_crc_next = crc_new;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid   <= 1'b0;
      frame_open  <= 1'b0;
      running_crc <= CRC_INIT;
    end else begin
      if (accept) begin
        job_valid   <= 1'b1;
        frame_open  <= frame_open_next;
        running_crc <= running_crc_next;
      end else if (job_pop) begin
        job_valid <= 1'b0;
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

>>> hw/rtl/sfe_emitter.sv
// ----------------------------------------------------------------------------
// sfe_emitter
// Walks the current job one line byte per cycle into the output register,
// while unstalled: header, escaped data, escaped CRC and the closing byte.
// ----------------------------------------------------------------------------
module sfe_emitter
  import sfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] slot_address,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] line_byte,
  output logic              run_last,
  output logic              frame_end
);

  typedef enum logic [9:0] {
    PH_HDR0    = 10'b00_0000_0001,
    PH_HDR1    = 10'b00_0000_0010,
    PH_HDR2    = 10'b00_0000_0100,
    PH_HDR3    = 10'b00_0000_1000,
    PH_HDR4    = 10'b00_0001_0000,
    PH_DAT     = 10'b00_0010_0000,
    PH_DAT_ESC = 10'b00_0100_0000,
    PH_CRC     = 10'b00_1000_0000,
    PH_CRC_ESC = 10'b01_0000_0000,
    PH_TAIL    = 10'b10_0000_0000
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  phase_t            cur_phase;
  logic              first;
  logic              done;
  logic              load;
  logic [BYTE_W-1:0] byte_val;
  logic              data_esc;
  logic              crc_esc;

  assign load    = job_valid && (!out_valid || out_ready);
  assign job_pop = load && done;

  assign data_esc = needs_escape(job.data);
  assign crc_esc  = needs_escape(job.crc);

  // Pick the entry phase for a fresh job
  always_comb begin
    if (first) begin
      if (job.hdr) begin
        cur_phase = PH_HDR0;
      end else if (job.data_en) begin
        cur_phase = PH_DAT;
      end else begin
        cur_phase = PH_CRC;
      end
    end else begin
      cur_phase = phase;
    end
  end

  // Byte for this phase and where to go next
  always_comb begin
    byte_val   = FEND;
    phase_next = PH_TAIL;
    done       = 1'b0;
    case (cur_phase)
      PH_HDR0: begin
        byte_val   = FEND;
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        byte_val   = {{(BYTE_W-SLOT_W){1'b0}}, slot_address};
        phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        byte_val   = HDR_PAD;
        phase_next = PH_HDR3;
      end
      PH_HDR3: begin
        byte_val   = HDR_PAD;
        phase_next = PH_HDR4;
      end
      PH_HDR4: begin
        byte_val   = HDR_PAD;
        phase_next = job.data_en ? PH_DAT : PH_CRC;
      end
      PH_DAT: begin
        byte_val = data_esc ? FESC : job.data;
        if (data_esc) begin
          phase_next = PH_DAT_ESC;
        end else if (job.crc_en) begin
          phase_next = PH_CRC;
        end else begin
          done = 1'b1;
        end
      end
      PH_DAT_ESC: begin
        byte_val = (job.data == FEND) ? TFEND : TFESC;
        if (job.crc_en) begin
          phase_next = PH_CRC;
        end else begin
          done = 1'b1;
        end
      end
      PH_CRC: begin
        byte_val   = crc_esc ? FESC : job.crc;
        phase_next = crc_esc ? PH_CRC_ESC : PH_TAIL;
      end
      PH_CRC_ESC: begin
        byte_val   = (job.crc == FEND) ? TFEND : TFESC;
        phase_next = PH_TAIL;
      end
      PH_TAIL: begin
        byte_val = FEND;
        done     = 1'b1;
      end
      default: begin
        byte_val = FEND;
        done     = 1'b1;
      end
    endcase
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      first     <= 1'b1;
      phase     <= PH_HDR0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        first     <= done;
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload; held while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      line_byte <= byte_val;
      run_last  <= done;
      frame_end <= done && job.crc_en;
    end
  end

endmodule

>>> hw/rtl/slip_frame_encoder_crc8_top.sv
// ----------------------------------------------------------------------------
// slip_frame_encoder_crc8_top
// SLIP response-frame encoder with CRC-8 (poly 0x07, init 0, MSB first).
//
// Input channel (in_valid/in_ready): one payload byte per transaction with
// last_byte marking the end of a frame, or empty_frame for a frame with no
// payload. The first transaction of a frame is preceded by the header C0,
// slot address, 00, 00, 00.
// Output channel (out_valid/out_ready): one line byte per transaction;
// run_last flags the final byte caused by an input transaction and
// frame_end flags the closing C0.
// The first line byte passes the job register, then the output register.
// Throughput: one line byte per cycle while out_ready is high, set by the
// single output register; a transaction yields 1 to 10 line bytes
// (1 for a plain mid-frame byte, 2 for an escaped one).
// A new transaction is accepted in the cycle its predecessor's last byte
// enters the output register.
// Reset clears the frame state (no frame open, CRC zero), the slot address
// and both valid flags. When the receiver stalls the output byte holds and
// the job stage fills, after which in_ready drops.
// cfg_write_en/cfg_write_data load the slot address; write only when idle.
// ----------------------------------------------------------------------------
module slip_frame_encoder_crc8_top
  import sfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [SLOT_W-1:0] cfg_write_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] payload_byte,
  input  logic              last_byte,
  input  logic              empty_frame,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] line_byte,
  output logic              run_last,
  output logic              frame_end
);

  logic [SLOT_W-1:0] slot_address;
  logic              job_valid;
  logic              job_pop;
  job_t              job;

  // Slot address register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_address <= '0;
    end else if (cfg_write_en) begin
      slot_address <= cfg_write_data;
    end
  end

  sfe_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .empty_frame  (empty_frame),
    .job_pop      (job_pop),
    .job_valid    (job_valid),
    .job          (job)
  );

  sfe_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .slot_address (slot_address),
    .job_valid    (job_valid),
    .job          (job),
    .job_pop      (job_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_byte    (line_byte),
    .run_last     (run_last),
    .frame_end    (frame_end)
  );

  // A closing byte is always the end delimiter and ends its transaction
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last && (line_byte == FEND))
    else $error("frame_end without run_last or on a non-delimiter byte");

  // An escape lead is never the last byte of a transaction
  a_esc_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (line_byte == FESC) |-> !run_last)
    else $error("escape lead byte flagged as last");

  // An accepted transaction lands in the job stage
  a_accept_job: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> job_valid)
    else $error("accepted transaction lost before the job stage");

  // The job stage only empties through the emitter
  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid)
    else $error("job popped while the job stage is empty");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SLIP response-frame encoder with CRC-8.
// Payload bytes, frame ends and empty frames go in over a valid/ready input.
// Each accepted transaction is framed by a local predictor into the line
// bytes it should produce. Every line byte that leaves the encoder is checked
// against the oldest prediction. A short scripted run covers header, escape
// and empty-frame cases. Random frames follow under several slot addresses,
// with random gaps on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb
  import sfe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES     = 7;
  localparam int SETTLE_CYCLES    = 6;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_ITEMS     = 370;
  localparam int RANDOM_PHASES    = 6;
  localparam int NO_GAP_PHASE     = 3;
  localparam int HOLD_PHASE       = 4;

  // One line byte as it should appear on the output
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_last;
    logic              frame_end;
  } line_beat_t;

  // Scripted stimulus: an input transaction or a slot address write
  typedef enum logic {ROW_ITEM, ROW_SLOT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [BYTE_W-1:0] data;      // payload byte, or slot address for ROW_SLOT
    logic              last;
    logic              empty;
    logic [3:0]        n_lines;   // expected line bytes, 0 where not typed in
  } script_row_t;

  localparam int N_ROWS = 20;
  localparam script_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
    '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 4'd7},  // empty frame straight after reset
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 4'd8},  // single-byte frame, CRC stays zero
    '{ROW_ITEM, 8'hC0, 1'b0, 1'b0, 4'd7},  // header plus escaped end code
    '{ROW_ITEM, 8'hDB, 1'b0, 1'b0, 4'd2},
    '{ROW_ITEM, 8'hDC, 1'b0, 1'b0, 4'd1},
    '{ROW_ITEM, 8'hDD, 1'b0, 1'b0, 4'd1},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 4'd1},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b0, 4'd0},
    '{ROW_ITEM, 8'h80, 1'b0, 1'b0, 4'd6},
    '{ROW_ITEM, 8'h7F, 1'b0, 1'b0, 4'd1},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 4'd7},  // empty frame abandons the open one
    '{ROW_ITEM, 8'hC0, 1'b1, 1'b0, 4'd0},
    '{ROW_ITEM, 8'hDB, 1'b1, 1'b0, 4'd0},
    '{ROW_SLOT, 8'h0F, 1'b0, 1'b0, 4'd0},
    '{ROW_ITEM, 8'hAA, 1'b0, 1'b1, 4'd7},
    '{ROW_ITEM, 8'hFF, 1'b1, 1'b0, 4'd0},
    '{ROW_ITEM, 8'h55, 1'b0, 1'b0, 4'd6},
    '{ROW_ITEM, 8'hC0, 1'b1, 1'b0, 4'd0},
    '{ROW_SLOT, 8'h00, 1'b0, 1'b0, 4'd0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 4'd7}
  };

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              cfg_write_en   = 1'b0;
  logic [SLOT_W-1:0] cfg_write_data = '0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] payload_byte   = '0;
  logic              last_byte      = 1'b0;
  logic              empty_frame    = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [BYTE_W-1:0] line_byte;
  logic              run_last;
  logic              frame_end;

  // Predictor state
  logic [SLOT_W-1:0] slot_addr  = '0;
  logic [BYTE_W-1:0] frame_crc  = CRC_INIT;
  logic              frame_open = 1'b0;

  line_beat_t pending_line [$];
  int         fail_count    = 0;
  int         items_sent    = 0;
  bit         gaps_on       = 1'b1;
  bit         sink_hold_req = 1'b0;

  slip_frame_encoder_crc8_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .payload_byte   (payload_byte),
    .last_byte      (last_byte),
    .empty_frame    (empty_frame),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .line_byte      (line_byte),
    .run_last       (run_last),
    .frame_end      (frame_end)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // CRC-8 over one byte, MSB first
  function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] c,
                                                 input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] r;
    r = c ^ d;
    repeat (BYTE_W) r = r[BYTE_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // Payload byte that brings the running CRC to the given value
  function automatic logic [BYTE_W-1:0] byte_for_crc(input logic [BYTE_W-1:0] want);
    for (int d = 0; d < 256; d++) begin
      if (crc_step(frame_crc, d[BYTE_W-1:0]) == want) return d[BYTE_W-1:0];
    end
    return '0;
  endfunction

  function automatic void push_line(input logic [BYTE_W-1:0] b, input logic fe);
    pending_line.push_back('{b, 1'b0, fe});
  endfunction

  function automatic void push_escaped(input logic [BYTE_W-1:0] b);
    if (b == FEND) begin
      push_line(FESC, 1'b0);
      push_line(TFEND, 1'b0);
    end else if (b == FESC) begin
      push_line(FESC, 1'b0);
      push_line(TFESC, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  function automatic void push_header();
    push_line(FEND, 1'b0);
    push_line({{(BYTE_W-SLOT_W){1'b0}}, slot_addr}, 1'b0);
    repeat (3) push_line(HDR_PAD, 1'b0);
  endfunction

  // Frame one accepted transaction into its line bytes; return how many
  function automatic int frame_item(input logic [BYTE_W-1:0] d, input logic l,
                                    input logic e);
    int start;
    start = pending_line.size();
    if (e) begin
      push_header();
      push_line(CRC_INIT, 1'b0);
      push_line(FEND, 1'b1);
      frame_crc  = CRC_INIT;
      frame_open = 1'b0;
    end else begin
      if (!frame_open) begin
        push_header();
        frame_crc  = CRC_INIT;
        frame_open = 1'b1;
      end
      frame_crc = crc_step(frame_crc, d);
      push_escaped(d);
      if (l) begin
        push_escaped(frame_crc);
        push_line(FEND, 1'b1);
        frame_crc  = CRC_INIT;
        frame_open = 1'b0;
      end
    end
    pending_line[pending_line.size()-1].run_last = 1'b1;
    return pending_line.size() - start;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one transaction, hold it until accepted, then predict its output
  task automatic offer(input logic [BYTE_W-1:0] d, input logic l, input logic e,
                       output int n);
    while (gaps_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    payload_byte <= d;
    last_byte    <= l;
    empty_frame  <= e;
    do @(posedge clk); while (!in_ready);
    n = frame_item(d, l, e);
    items_sent++;
  endtask

  // Drain the output, let the pipeline settle, then load a new slot address
  task automatic write_slot(input logic [SLOT_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_line.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    slot_addr = v;
  endtask

  // One random frame, or noise: a stray empty frame or a frame cut short
  task automatic random_traffic();
    int len;
    int cut;
    int n;
    logic [BYTE_W-1:0] d;
    if ($urandom_range(99) < 10) begin
      offer(BYTE_W'($urandom), 1'($urandom_range(1)), 1'b1, n);
      return;
    end
    len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
    cut = ($urandom_range(99) < 8) ? $urandom_range(len - 1) : len;
    for (int k = 0; k < len; k++) begin
      if (k == cut) begin
        offer(BYTE_W'($urandom), 1'($urandom_range(1)), 1'b1, n);
        return;
      end
      if (k == len - 1 && $urandom_range(99) < 20) begin
        // steer the CRC onto a code that needs escaping
        d = byte_for_crc($urandom_range(1) ? FEND : FESC);
      end else if ($urandom_range(99) < 25) begin
        case ($urandom_range(3))
          0:       d = FEND;
          1:       d = FESC;
          2:       d = TFEND;
          default: d = TFESC;
        endcase
      end else begin
        d = BYTE_W'($urandom);
      end
      offer(d, k == len - 1, 1'b0, n);
    end
  endtask

  // Stimulus
  initial begin
    int n;
    int phase_end;
    logic [SLOT_W-1:0] slot;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // walk the scripted rows
    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_SLOT) begin
        write_slot(DIRECTED_ROWS[i].data[SLOT_W-1:0]);
      end else begin
        offer(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].empty, n);
        if (DIRECTED_ROWS[i].n_lines != 0 && n != DIRECTED_ROWS[i].n_lines) begin
          $display("%0t: row %0d line count expected %0d, got %0d", $time, i,
                   DIRECTED_ROWS[i].n_lines, n);
          fail_count++;
        end
      end
    end

    // random phases, each under its own slot address
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1:       slot = '1;
        2:       slot = '0;
        default: slot = SLOT_W'($urandom_range(15));
      endcase
      gaps_on = (p != NO_GAP_PHASE);
      write_slot(slot);
      if (p == HOLD_PHASE) sink_hold_req = 1'b1;
      phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_end) random_traffic();
    end

    in_valid <= 1'b0;
    while (pending_line.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Output side: random back-pressure, and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !(gaps_on && $urandom_range(99) < 38);
    end
  end

  // Check each output transaction against the oldest prediction
  always @(posedge clk) begin
    line_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_line.size() == 0) begin
        $display("%0t: line_byte expected none, got %02h", $time, line_byte);
        fail_count++;
      end else begin
        want = pending_line.pop_front();
        check_field("line_byte", want.data, line_byte);
        check_field("run_last", want.run_last, run_last);
        check_field("frame_end", want.frame_end, frame_end);
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

endmodule

>>> slip_frame_encoder_crc8_top.f
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_framer.sv
hw/rtl/sfe_emitter.sv
hw/rtl/slip_frame_encoder_crc8_top.sv
tb/sv/tb.sv
